/* hdl/mvna_pkg.sv */
// Shared types and constants for the mesh vertex normal accumulator.
// Request and result payload structs, op and kind codes, field widths.
// No dependencies.
`default_nettype none

package mvna_pkg;

    localparam int VERTEX_SLOTS_DEF = 1024;
    localparam int COORD_BITS_DEF   = 16;

    localparam int IDX_W   = 10;
    localparam int OP_W    = 2;
    localparam int FIELD_W = 16;
    localparam int NORM_W  = 40;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_TRI  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic KIND_FACE   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    localparam logic signed [NORM_W-1:0] NORM_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [NORM_W-1:0] NORM_MIN = 40'sh80_0000_0000;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [IDX_W-1:0]          vertex_index;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic signed [FIELD_W-1:0] coord_z;
        logic [IDX_W-1:0]          corner_a;
        logic [IDX_W-1:0]          corner_b;
        logic [IDX_W-1:0]          corner_c;
    } cmd_t;

    typedef struct packed {
        logic                     kind;
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
    } res_t;

endpackage

`default_nettype wire

/* hdl/mesh_vertex_normal_accumulator_top.sv */
// Top level of the mesh vertex normal accumulator: sequencer, cross-product
// datapath, result register. Uses mvna_pkg and two mvna_ram instances.
`default_nettype none

// One request at a time. A load writes both stores on acceptance; a normal
// read passes through states RD0, RD1 and EMIT; a triangle makes three reads
// of the vertex store, three cross-product components through a pair of
// multipliers (multiply, then subtract and saturate), and three
// read-modify-write passes (AR, then AW) over the single accumulator store.
// A result that waits in the output register does not block the next
// request; only the emit step waits for the register to drain. Slots that
// were never loaded read as garbage; no clearing pass is run after reset.
module mesh_vertex_normal_accumulator_top #(
    parameter int VERTEX_SLOTS = mvna_pkg::VERTEX_SLOTS_DEF,
    parameter int COORD_BITS   = mvna_pkg::COORD_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cmd_valid,
    output logic              cmd_stall,
    input  wire mvna_pkg::cmd_t cmd,
    output logic              res_valid,
    input  wire logic         res_stall,
    output mvna_pkg::res_t    res
);

    localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int NW = mvna_pkg::NORM_W;
    localparam int XW = mvna_pkg::IDX_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_VA   = 4'd1;
    localparam logic [3:0] S_VB   = 4'd2;
    localparam logic [3:0] S_VC   = 4'd3;
    localparam logic [3:0] S_VD   = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_SUB  = 4'd6;
    localparam logic [3:0] S_EMIT = 4'd7;
    localparam logic [3:0] S_AR   = 4'd8;
    localparam logic [3:0] S_AW   = 4'd9;
    localparam logic [3:0] S_RD0  = 4'd10;
    localparam logic [3:0] S_RD1  = 4'd11;

    function automatic logic in_range(input logic [XW-1:0] idx);
        return 32'(idx) < VERTEX_SLOTS;
    endfunction

    function automatic logic signed [NW-1:0] sat_norm(input logic signed [SW-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > 64'(mvna_pkg::NORM_MAX))
            return mvna_pkg::NORM_MAX;
        if (w < 64'(mvna_pkg::NORM_MIN))
            return mvna_pkg::NORM_MIN;
        return NW'(w);
    endfunction

    function automatic logic signed [NW-1:0] sat_add(input logic signed [NW-1:0] a,
                                                     input logic signed [NW-1:0] b);
        logic signed [NW:0] s;
        s = (NW+1)'(a) + (NW+1)'(b);
        if (s[NW] != s[NW-1])
            return s[NW] ? mvna_pkg::NORM_MIN : mvna_pkg::NORM_MAX;
        return s[NW-1:0];
    endfunction

    // ---------------- state
    logic [3:0]             state_reg, state_next;
    logic [1:0]             step_reg, step_next;
    logic                   res_valid_reg, res_valid_next;
    mvna_pkg::cmd_t         cmd_reg, cmd_next;
    mvna_pkg::res_t         res_reg, res_next;
    logic signed [CW-1:0]   va_reg [3], va_next [3];
    logic signed [CW-1:0]   vb_reg [3], vb_next [3];
    logic signed [DW-1:0]   p1_reg [3], p1_next [3];
    logic signed [DW-1:0]   p2_reg [3], p2_next [3];
    logic signed [PW-1:0]   prod0_reg, prod0_next;
    logic signed [PW-1:0]   prod1_reg, prod1_next;
    logic signed [NW-1:0]   nrm_reg [3], nrm_next [3];

    // ---------------- memories
    logic                vram_we;
    logic [AW-1:0]       vram_waddr, vram_raddr;
    logic [3*CW-1:0]     vram_wdata, vram_rdata;
    logic                aram_we;
    logic [AW-1:0]       aram_waddr, aram_raddr;
    logic [3*NW-1:0]     aram_wdata, aram_rdata;

    mvna_ram #(.WIDTH(3*CW), .DEPTH(VERTEX_SLOTS)) u_vertex_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    mvna_ram #(.WIDTH(3*NW), .DEPTH(VERTEX_SLOTS)) u_accum_ram (
        .clk   (clk),
        .we    (aram_we),
        .waddr (aram_waddr),
        .wdata (aram_wdata),
        .raddr (aram_raddr),
        .rdata (aram_rdata)
    );

    logic                 cmd_acc;
    logic                 out_free;
    logic [XW-1:0]        corner_idx;
    logic signed [CW-1:0] vr [3];
    logic signed [NW-1:0] ar [3];
    logic signed [DW-1:0] m0a, m0b, m1a, m1b;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        case (step_reg)
            2'd0:    corner_idx = cmd_reg.corner_a;
            2'd1:    corner_idx = cmd_reg.corner_b;
            default: corner_idx = cmd_reg.corner_c;
        endcase
    end

    // slice the store words; x in the top lane
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vr[i] = $signed(vram_rdata[(2-i)*CW +: CW]);
            ar[i] = $signed(aram_rdata[(2-i)*NW +: NW]);
        end
    end

    // operand pairs of component step_reg: n = m0a*m0b - m1a*m1b
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                m0a = p1_reg[1]; m0b = p2_reg[2]; m1a = p1_reg[2]; m1b = p2_reg[1];
            end
            2'd1:
            begin
                m0a = p1_reg[2]; m0b = p2_reg[0]; m1a = p1_reg[0]; m1b = p2_reg[2];
            end
            default:
            begin
                m0a = p1_reg[0]; m0b = p2_reg[1]; m1a = p1_reg[1]; m1b = p2_reg[0];
            end
        endcase
    end

    // memory ports
    always_comb
    begin
        vram_we    = cmd_acc && (cmd.op == mvna_pkg::OP_LOAD) && in_range(cmd.vertex_index);
        vram_waddr = AW'(cmd.vertex_index);
        vram_wdata = {CW'(unsigned'(cmd.coord_x)),
                      CW'(unsigned'(cmd.coord_y)),
                      CW'(unsigned'(cmd.coord_z))};
        case (state_reg)
            S_VA:    vram_raddr = AW'(cmd_reg.corner_a);
            S_VB:    vram_raddr = AW'(cmd_reg.corner_b);
            default: vram_raddr = AW'(cmd_reg.corner_c);
        endcase

        aram_raddr = (state_reg == S_RD0) ? AW'(cmd_reg.vertex_index) : AW'(corner_idx);
        if (state_reg == S_AW)
        begin
            aram_we    = in_range(corner_idx);
            aram_waddr = AW'(corner_idx);
            aram_wdata = {sat_add(ar[0], nrm_reg[0]),
                          sat_add(ar[1], nrm_reg[1]),
                          sat_add(ar[2], nrm_reg[2])};
        end
        else
        begin
            aram_we    = vram_we;
            aram_waddr = AW'(cmd.vertex_index);
            aram_wdata = '0;
        end
    end

    // sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        res_valid_next = res_valid_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        prod0_next     = prod0_reg;
        prod1_next     = prod1_reg;
        nrm_next       = nrm_reg;

        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    cmd_next = cmd;
                    step_next = 2'd0;
                    if (cmd.op == mvna_pkg::OP_TRI)
                        state_next = S_VA;
                    else if (cmd.op == mvna_pkg::OP_READ)
                        state_next = S_RD0;
                end
            end
            S_VA:
                state_next = S_VB;
            S_VB:
            begin
                for (int i = 0; i < 3; i++)
                    va_next[i] = in_range(cmd_reg.corner_a) ? vr[i] : '0;
                state_next = S_VC;
            end
            S_VC:
            begin
                for (int i = 0; i < 3; i++)
                    vb_next[i] = in_range(cmd_reg.corner_b) ? vr[i] : '0;
                state_next = S_VD;
            end
            S_VD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p1_next[i] = DW'(va_reg[i]) - DW'(vb_reg[i]);
                    p2_next[i] = DW'(vb_reg[i])
                               - (in_range(cmd_reg.corner_c) ? DW'(vr[i]) : DW'(0));
                end
                step_next  = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod0_next = m0a * m0b;
                prod1_next = m1a * m1b;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                nrm_next[step_reg] = sat_norm(SW'(prod0_reg) - SW'(prod1_reg));
                if (step_reg == 2'd2)
                begin
                    step_next  = 2'd0;
                    state_next = S_EMIT;
                end
                else
                begin
                    step_next  = step_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next    = 1'b1;
                    res_next.kind     = (cmd_reg.op == mvna_pkg::OP_READ)
                                      ? mvna_pkg::KIND_VERTEX : mvna_pkg::KIND_FACE;
                    res_next.normal_x = nrm_reg[0];
                    res_next.normal_y = nrm_reg[1];
                    res_next.normal_z = nrm_reg[2];
                    step_next         = 2'd0;
                    state_next        = (cmd_reg.op == mvna_pkg::OP_TRI) ? S_AR : S_IDLE;
                end
            end
            S_AR:
                state_next = S_AW;
            S_AW:
            begin
                // write happens on the memory port this cycle
                if (step_reg == 2'd2)
                    state_next = S_IDLE;
                else
                begin
                    step_next  = step_reg + 2'd1;
                    state_next = S_AR;
                end
            end
            S_RD0:
                state_next = S_RD1;
            S_RD1:
            begin
                for (int i = 0; i < 3; i++)
                    nrm_next[i] = in_range(cmd_reg.vertex_index) ? ar[i] : '0;
                state_next = S_EMIT;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        va_reg    <= va_next;
        vb_reg    <= vb_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        prod0_reg <= prod0_next;
        prod1_reg <= prod1_next;
        nrm_reg   <= nrm_next;
    end

endmodule

`default_nettype wire

/* hdl/mvna_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone, no package dependency.
`default_nettype none

module mvna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
